[design/lbmcol_pkg.sv]
// shared types, constants and helper functions of the d2q9 collision block
`default_nettype none
package lbmcol_pkg;

  localparam int NDIR = 9;

  // weight classes: rest 16/36, axis 4/36, diagonal 1/36
  localparam logic [1:0] WCLS_REST = 2'd0;
  localparam logic [1:0] WCLS_AXIS = 2'd1;
  localparam logic [1:0] WCLS_DIAG = 2'd2;

  // divider datapath width and latency
  localparam int DIV_W   = 62;
  localparam int DIV_LAT = 33;
  // collision lane latency
  localparam int LANE_LAT = 11;
  // moment summation latency
  localparam int MOM_LAT = 2;

  // floor(2^26 / 9), exact to one after a single correction for values below 2^22
  localparam int          RECIP9_SHIFT = 26;
  localparam logic [22:0] RECIP9       = 23'd7456540;

  localparam logic [15:0] RELAX_RESET = 16'd16384;
  localparam int          OMEGA_BITS  = 14;

  typedef logic signed [31:0] fix_t;
  typedef fix_t dist_vec_t [NDIR];

  typedef struct packed {
    fix_t in_rest;
    fix_t in_east;
    fix_t in_north;
    fix_t in_west;
    fix_t in_south;
    fix_t in_northeast;
    fix_t in_northwest;
    fix_t in_southwest;
    fix_t in_southeast;
  } in_item_t;

  typedef struct packed {
    fix_t out_rest;
    fix_t out_east;
    fix_t out_north;
    fix_t out_west;
    fix_t out_south;
    fix_t out_northeast;
    fix_t out_northwest;
    fix_t out_southwest;
    fix_t out_southeast;
    fix_t density;
    fix_t velocity_x;
    fix_t velocity_y;
  } out_item_t;

  function automatic fix_t sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  function automatic logic signed [1:0] dir_cx(input int unsigned d);
    case (d)
      1, 5, 8: return 2'sd1;
      3, 6, 7: return -2'sd1;
      default: return 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] dir_cy(input int unsigned d);
    case (d)
      2, 5, 6: return 2'sd1;
      4, 7, 8: return -2'sd1;
      default: return 2'sd0;
    endcase
  endfunction

  function automatic logic [1:0] dir_class(input int unsigned d);
    case (d)
      0:          return WCLS_REST;
      1, 2, 3, 4: return WCLS_AXIS;
      default:    return WCLS_DIAG;
    endcase
  endfunction

endpackage
`default_nettype wire

[design/lbmcol_if.sv]
// valid/ready channel interfaces for cell input and collision result
`default_nettype none
interface lbmcol_in_if
  import lbmcol_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface lbmcol_out_if
  import lbmcol_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

[design/lbmcol_moments.sv]
// two-stage density and momentum summation with saturation
`default_nettype none
module lbmcol_moments
  import lbmcol_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      en,
  input  wire dist_vec_t f_in,
  output dist_vec_t      f_out,
  output fix_t           rho,
  output fix_t           mx,
  output fix_t           my
);

  logic signed [33:0] ra, rb, rc, mxa, mxb, mya, myb;
  dist_vec_t          f1;
  logic signed [35:0] rsum, mxsum, mysum;

  always_ff @(posedge clk) begin
    if (en) begin
      ra  <= 34'(f_in[0]) + 34'(f_in[1]) + 34'(f_in[2]);
      rb  <= 34'(f_in[3]) + 34'(f_in[4]) + 34'(f_in[5]);
      rc  <= 34'(f_in[6]) + 34'(f_in[7]) + 34'(f_in[8]);
      mxa <= 34'(f_in[1]) - 34'(f_in[3]) + 34'(f_in[5]);
      mxb <= 34'(f_in[8]) - 34'(f_in[6]) - 34'(f_in[7]);
      mya <= 34'(f_in[2]) - 34'(f_in[4]) + 34'(f_in[5]);
      myb <= 34'(f_in[6]) - 34'(f_in[7]) - 34'(f_in[8]);
      f1  <= f_in;
    end
  end

  assign rsum  = 36'(ra) + 36'(rb) + 36'(rc);
  assign mxsum = 36'(mxa) + 36'(mxb);
  assign mysum = 36'(mya) + 36'(myb);

  always_ff @(posedge clk) begin
    if (en) begin
      rho   <= sat32(64'(rsum));
      mx    <= sat32(64'(mxsum));
      my    <= sat32(64'(mysum));
      f_out <= f1;
    end
  end

endmodule
`default_nettype wire

[design/lbmcol_divider.sv]
// pipelined restoring divider, one quotient bit per stage, q = sat32(trunc(num*2^F/den)), zero if den <= 0
`default_nettype none
module lbmcol_divider
  import lbmcol_pkg::*;
#(
  parameter int FRAC_BITS = 28
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire fix_t num,
  input  wire fix_t den,
  output fix_t      quo
);

  localparam int QB = 31;

  logic [DIV_W-1:0] rem  [QB+1];
  logic [QB-1:0]    qacc [QB+1];
  logic [30:0]      dd   [QB+1];
  logic             neg  [QB+1];
  logic             pos  [QB+1];
  logic             ovf  [QB+1];

  logic [32:0]      num_neg;
  logic [31:0]      mag;
  logic [DIV_W-1:0] nval, dlim;

  assign num_neg = -33'(num);
  assign mag     = num[31] ? num_neg[31:0] : num[31:0];
  assign nval    = DIV_W'(mag) << FRAC_BITS;
  assign dlim    = DIV_W'(den[30:0]) << QB;

  // operand prep and overflow test
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= nval;
      qacc[0] <= '0;
      dd[0]   <= den[30:0];
      neg[0]  <= num[31];
      pos[0]  <= !den[31] && (den != '0);
      ovf[0]  <= nval >= dlim;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int J = QB - 1 - k;
    logic [DIV_W-1:0] dsh;
    logic             ge;
    assign dsh = DIV_W'(dd[k]) << J;
    assign ge  = rem[k] >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? rem[k] - dsh : rem[k];
        qacc[k+1] <= qacc[k] | (QB'(ge) << J);
        dd[k+1]   <= dd[k];
        neg[k+1]  <= neg[k];
        pos[k+1]  <= pos[k];
        ovf[k+1]  <= ovf[k];
      end
    end
  end

  logic [31:0] qneg;
  assign qneg = -{1'b0, qacc[QB]};

  // sign, saturation, zero for non-positive density
  always_ff @(posedge clk) begin
    if (en) begin
      if (!pos[QB]) begin
        quo <= '0;
      end else if (ovf[QB]) begin
        quo <= neg[QB] ? 32'sh80000000 : 32'sh7fffffff;
      end else begin
        quo <= neg[QB] ? qneg : {1'b0, qacc[QB]};
      end
    end
  end

endmodule
`default_nettype wire

[design/lbmcol_lane.sv]
// per-direction equilibrium and bgk relaxation, eleven register stages
`default_nettype none
module lbmcol_lane
  import lbmcol_pkg::*;
#(
  parameter int          FRAC_BITS = 28,
  parameter int unsigned DIR       = 0
) (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [15:0] omega,
  input  wire fix_t        ux,
  input  wire fix_t        uy,
  input  wire fix_t        rho,
  input  wire fix_t        f,
  input  wire logic [63:0] usq,
  output fix_t             res
);

  localparam logic signed [1:0] CX  = dir_cx(DIR);
  localparam logic signed [1:0] CY  = dir_cy(DIR);
  localparam logic [1:0]        CLS = dir_class(DIR);
  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] BIAS = 64'sd19327352832;

  // stage 1: projected velocity
  logic signed [33:0] tx, ty;
  fix_t cu1, rho1, f1;
  always_comb begin
    if (CX == 2'sd1) tx = 34'(ux);
    else if (CX == -2'sd1) tx = -34'(ux);
    else tx = '0;
    if (CY == 2'sd1) ty = 34'(uy);
    else if (CY == -2'sd1) ty = -34'(uy);
    else ty = '0;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cu1  <= sat32(64'(tx + ty));
      rho1 <= rho;
      f1   <= f;
    end
  end

  // stage 2: square of projection
  logic signed [63:0] cusq;
  logic signed [63:0] cu2_2;
  fix_t cu2, rho2, f2;
  assign cusq = cu1 * cu1;
  always_ff @(posedge clk) begin
    if (en) begin
      cu2_2 <= cusq >>> FRAC_BITS;
      cu2   <= cu1;
      rho2  <= rho1;
      f2    <= f1;
    end
  end

  // stage 3: polynomial term
  logic signed [63:0] psum, usq_s;
  fix_t p3, rho3, f3;
  assign usq_s = $signed(usq);
  assign psum  = ONE + 64'sd3 * 64'(cu2) + ((64'sd9 * cu2_2) >>> 1)
               - ((64'sd3 * usq_s) >>> 1);
  always_ff @(posedge clk) begin
    if (en) begin
      p3   <= sat32(psum);
      rho3 <= rho2;
      f3   <= f2;
    end
  end

  // stage 4: density times polynomial
  logic signed [63:0] prod4_c, prod4;
  fix_t f4;
  assign prod4_c = rho3 * p3;
  always_ff @(posedge clk) begin
    if (en) begin
      prod4 <= prod4_c;
      f4    <= f3;
    end
  end

  // stage 5: weight scaling, range test, bias to non-negative
  logic signed [63:0] rp, m5, tb;
  logic [35:0] t5;
  logic hi5, lo5;
  fix_t f5;
  always_comb begin
    rp = prod4 >>> FRAC_BITS;
    case (CLS)
      WCLS_REST: m5 = rp <<< 2;
      WCLS_AXIS: m5 = rp;
      default:   m5 = rp >>> 2;
    endcase
    tb = m5 + BIAS;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      t5  <= tb[35:0];
      hi5 <= m5 >= BIAS;
      lo5 <= m5 < -BIAS;
      f5  <= f4;
    end
  end

  // stage 6: estimate of upper quotient by 9
  logic [40:0] ph;
  logic [14:0] qh6;
  logic [35:0] t6;
  logic hi6, lo6;
  fix_t f6;
  assign ph = t5[35:18] * RECIP9;
  always_ff @(posedge clk) begin
    if (en) begin
      qh6 <= ph[40:RECIP9_SHIFT];
      t6  <= t5;
      hi6 <= hi5;
      lo6 <= lo5;
      f6  <= f5;
    end
  end

  // stage 7: correct upper quotient, form middle dividend
  logic [21:0] rh_raw, rh_fix;
  logic        rh_ge;
  logic [14:0] qh7;
  logic [21:0] mid7;
  logic hi7, lo7;
  fix_t f7;
  assign rh_raw = 22'(t6[35:18]) - 22'(qh6) * 22'd9;
  assign rh_ge  = rh_raw >= 22'd9;
  assign rh_fix = rh_ge ? rh_raw - 22'd9 : rh_raw;
  always_ff @(posedge clk) begin
    if (en) begin
      qh7  <= rh_ge ? qh6 + 15'd1 : qh6;
      mid7 <= {rh_fix[3:0], t6[17:0]};
      hi7  <= hi6;
      lo7  <= lo6;
      f7   <= f6;
    end
  end

  // stage 8: estimate of lower quotient by 9
  logic [44:0] pm;
  logic [17:0] qm8;
  logic [21:0] mid8;
  logic [14:0] qh8;
  logic hi8, lo8;
  fix_t f8;
  assign pm = mid7 * RECIP9;
  always_ff @(posedge clk) begin
    if (en) begin
      qm8  <= pm[43:RECIP9_SHIFT];
      mid8 <= mid7;
      qh8  <= qh7;
      hi8  <= hi7;
      lo8  <= lo7;
      f8   <= f7;
    end
  end

  // stage 9: correct, remove bias, saturate equilibrium
  logic [21:0] rm_raw;
  logic [17:0] qm_fix;
  logic [33:0] quot, feq_b;
  fix_t feq9, f9;
  assign rm_raw = mid8 - 22'(qm8) * 22'd9;
  assign qm_fix = (rm_raw >= 22'd9) ? qm8 + 18'd1 : qm8;
  assign quot   = {1'b0, qh8, 18'b0} + 34'(qm_fix);
  assign feq_b  = quot - 34'h080000000;
  always_ff @(posedge clk) begin
    if (en) begin
      if (hi8) feq9 <= 32'sh7fffffff;
      else if (lo8) feq9 <= 32'sh80000000;
      else feq9 <= feq_b[31:0];
      f9 <= f8;
    end
  end

  // stage 10: relaxation product
  logic signed [32:0] diff;
  logic signed [49:0] prod10, prod10_c;
  fix_t f10;
  assign diff     = 33'(feq9) - 33'(f9);
  assign prod10_c = 50'(diff) * 50'($signed({1'b0, omega}));
  always_ff @(posedge clk) begin
    if (en) begin
      prod10 <= prod10_c;
      f10    <= f9;
    end
  end

  // stage 11: update and saturate
  logic signed [49:0] dsh;
  logic signed [36:0] upd;
  assign dsh = prod10 >>> OMEGA_BITS;
  assign upd = 37'(f10) + dsh[36:0];
  always_ff @(posedge clk) begin
    if (en) begin
      res <= sat32(64'(upd));
    end
  end

endmodule
`default_nettype wire

[design/d2q9_bgk_cell_collision.sv]
// top level of the d2q9 bgk collision pipeline for one lattice cell per transaction
// path from input transaction to result: summing stages, then dividers, then lanes
// throughput: one cell per cycle; the whole pipeline advances together and holds
//   when a result waits at the output register and the sink is not ready
// reset (rst, synchronous): clears all stage valid bits and sets relax_rate to 16384
// payload registers are not reset
`default_nettype none
module d2q9_bgk_cell_collision
  import lbmcol_pkg::*;
#(
  parameter int FRAC_BITS = 28
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        relax_rate_we,
  input  wire logic [15:0] relax_rate_wdata,
  lbmcol_in_if.sink        in_ch,
  lbmcol_out_if.source     out_ch
);

  localparam int LAT = MOM_LAT + DIV_LAT + LANE_LAT;

  // relaxation rate register
  logic [15:0] relax_rate;
  always_ff @(posedge clk) begin
    if (rst) begin
      relax_rate <= RELAX_RESET;
    end else if (relax_rate_we) begin
      relax_rate <= relax_rate_wdata;
    end
  end

  // global advance: move when the output register is empty or being drained
  logic en;
  logic [LAT-1:0] vld;
  assign en          = !vld[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_ch.valid};
    end
  end

  // unpack the cell into a direction-indexed vector
  dist_vec_t f_in;
  assign f_in[0] = in_ch.item.in_rest;
  assign f_in[1] = in_ch.item.in_east;
  assign f_in[2] = in_ch.item.in_north;
  assign f_in[3] = in_ch.item.in_west;
  assign f_in[4] = in_ch.item.in_south;
  assign f_in[5] = in_ch.item.in_northeast;
  assign f_in[6] = in_ch.item.in_northwest;
  assign f_in[7] = in_ch.item.in_southwest;
  assign f_in[8] = in_ch.item.in_southeast;

  // density and momentum
  dist_vec_t f_m;
  fix_t rho_m, mx_m, my_m;
  lbmcol_moments u_moments (
    .clk   (clk),
    .en    (en),
    .f_in  (f_in),
    .f_out (f_m),
    .rho   (rho_m),
    .mx    (mx_m),
    .my    (my_m)
  );

  // velocity dividers, zero when density is not positive
  fix_t ux, uy;
  lbmcol_divider #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk (clk), .en (en), .num (mx_m), .den (rho_m), .quo (ux)
  );
  lbmcol_divider #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk (clk), .en (en), .num (my_m), .den (rho_m), .quo (uy)
  );

  // distributions and density ride alongside the dividers
  dist_vec_t f_dly   [DIV_LAT];
  fix_t      rho_dly [DIV_LAT];
  always_ff @(posedge clk) begin
    if (en) begin
      f_dly[0]   <= f_m;
      rho_dly[0] <= rho_m;
      for (int s = 1; s < DIV_LAT; s++) begin
        f_dly[s]   <= f_dly[s-1];
        rho_dly[s] <= rho_dly[s-1];
      end
    end
  end

  // shared |u|^2, registered through sqx/sqy and usq, lined up with the lane squares
  logic signed [63:0] sqx_c, sqy_c;
  logic signed [63:0] sqx, sqy;
  logic [63:0] usq;
  assign sqx_c = ux * ux;
  assign sqy_c = uy * uy;
  always_ff @(posedge clk) begin
    if (en) begin
      sqx <= sqx_c >>> FRAC_BITS;
      sqy <= sqy_c >>> FRAC_BITS;
      usq <= sqx + sqy;
    end
  end

  // nine collision lanes
  dist_vec_t f_out;
  for (genvar d = 0; d < NDIR; d++) begin : g_lane
    lbmcol_lane #(.FRAC_BITS(FRAC_BITS), .DIR(d)) u_lane (
      .clk   (clk),
      .en    (en),
      .omega (relax_rate),
      .ux    (ux),
      .uy    (uy),
      .rho   (rho_dly[DIV_LAT-1]),
      .f     (f_dly[DIV_LAT-1][d]),
      .usq   (usq),
      .res   (f_out[d])
    );
  end

  // density and velocity delayed to meet the lane results
  fix_t rho_o [LANE_LAT];
  fix_t ux_o  [LANE_LAT];
  fix_t uy_o  [LANE_LAT];
  always_ff @(posedge clk) begin
    if (en) begin
      rho_o[0] <= rho_dly[DIV_LAT-1];
      ux_o[0]  <= ux;
      uy_o[0]  <= uy;
      for (int s = 1; s < LANE_LAT; s++) begin
        rho_o[s] <= rho_o[s-1];
        ux_o[s]  <= ux_o[s-1];
        uy_o[s]  <= uy_o[s-1];
      end
    end
  end

  // output transaction
  assign out_ch.valid              = vld[LAT-1];
  assign out_ch.item.out_rest      = f_out[0];
  assign out_ch.item.out_east      = f_out[1];
  assign out_ch.item.out_north     = f_out[2];
  assign out_ch.item.out_west      = f_out[3];
  assign out_ch.item.out_south     = f_out[4];
  assign out_ch.item.out_northeast = f_out[5];
  assign out_ch.item.out_northwest = f_out[6];
  assign out_ch.item.out_southwest = f_out[7];
  assign out_ch.item.out_southeast = f_out[8];
  assign out_ch.item.density       = rho_o[LANE_LAT-1];
  assign out_ch.item.velocity_x    = ux_o[LANE_LAT-1];
  assign out_ch.item.velocity_y    = uy_o[LANE_LAT-1];

  // a stalled result holds the input side too
  a_stall_back : assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted while output stalled");

  // velocities are zero for a non-positive density
  a_zero_vel : assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !(out_ch.item.density > 0) |->
      out_ch.item.velocity_x == 0 && out_ch.item.velocity_y == 0)
    else $error("nonzero velocity with non-positive density");

  // an accepted transaction enters the first stage
  a_enter : assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> vld[0])
    else $error("accepted transaction lost at entry");

endmodule
`default_nettype wire
